[hw/rtl/tsf_pkg.sv]
// constants and types shared by the turn signal flasher
package tsf_pkg;

    localparam int unsigned CfgWidth = 8;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [CfgWidth-1:0] OnTicksReset = 8'd5;
    localparam logic [CfgWidth-1:0] PeriodTicksReset = 8'd10;
    localparam logic [CfgWidth-1:0] MinCyclesReset = 8'd3;
    localparam logic [CfgWidth-1:0] CountMax = 8'd255;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_ON_TICKS = 2'd0,
        CFG_PERIOD_TICKS = 2'd1,
        CFG_MIN_CYCLES = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_LEFT = 4'b0010,
        MODE_RIGHT = 4'b0100,
        MODE_HAZARD = 4'b1000
    } t_mode;

endpackage

[hw/rtl/tsf_in_if.sv]
// button and tick word channel
interface tsf_in_if;
    logic valid;
    logic ready;
    logic action;
    logic btn_left;
    logic btn_right;
    logic btn_hazard;

    modport source (output valid, action, btn_left, btn_right, btn_hazard, input ready);
    modport sink (input valid, action, btn_left, btn_right, btn_hazard, output ready);
endinterface

[hw/rtl/tsf_out_if.sv]
// lamp command word channel
interface tsf_out_if;
    logic valid;
    logic ready;
    logic left_lamp;
    logic right_lamp;

    modport source (output valid, left_lamp, right_lamp, input ready);
    modport sink (input valid, left_lamp, right_lamp, output ready);
endinterface

[hw/rtl/turn_signal_flasher.sv]
// turn signal and hazard flasher top level
//
// i_btn carries one word per button change (action 0, with the three button
// levels) or per timer tick (action 1). o_lamp carries one word with both
// lamp commands for every tick of an active blink run, and one all-dark word
// when hazard is released after having been pressed. Other words give none.
// Configuration (on_ticks, period_ticks, min_cycles) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data, one register per write. The user must
// write it only while idle; the block itself does not enforce this.
//
// A word is held in the input register and its lamp word is registered
// in the output register. All state is updated by one pass of flag and
// 8-bit counter logic, so one word is taken every cycle while o_lamp does
// not stall. When o_lamp stalls the output register holds; the input
// register takes one more word only if it is empty, then i_btn.ready drops
// until the lamp word is taken. Synchronous reset returns to idle with
// both lamps dark and the configuration at 5 / 10 / 3.
module turn_signal_flasher
    import tsf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [CfgWidth-1:0]    i_cfg_data,
    tsf_in_if.sink                 i_btn,
    tsf_out_if.source              o_lamp
);

    // configuration
    logic [CfgWidth-1:0] r_on_ticks, r_period_ticks, r_min_cycles;

    // input register
    logic r_in_valid, r_in_action, r_in_left, r_in_right, r_in_hazard;

    // output register
    logic r_out_valid, r_out_left, r_out_right;
    logic n_out_valid;

    // flasher state
    t_mode               r_mode, n_mode;
    logic [CfgWidth-1:0] r_phase, n_phase, r_cycles, n_cycles;
    logic r_ticking, n_ticking;
    logic r_left_latched, n_left_latched, r_right_latched, n_right_latched;
    logic r_hazard_latched, n_hazard_latched;
    logic r_held_left, n_held_left, r_held_right, n_held_right;
    logic r_off_sent, n_off_sent;
    logic r_lamp_left, n_lamp_left, r_lamp_right, n_lamp_right;

    logic advance, process_word, lit, emit;

    assign advance = !r_out_valid || o_lamp.ready;
    assign process_word = r_in_valid && advance;
    assign i_btn.ready = !r_in_valid || advance;

    assign o_lamp.valid = r_out_valid;
    assign o_lamp.left_lamp = r_out_left;
    assign o_lamp.right_lamp = r_out_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_ticks <= OnTicksReset;
            r_period_ticks <= PeriodTicksReset;
            r_min_cycles <= MinCyclesReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ON_TICKS: r_on_ticks <= i_cfg_data;
                CFG_PERIOD_TICKS: r_period_ticks <= i_cfg_data;
                CFG_MIN_CYCLES: r_min_cycles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_btn.ready) begin
            r_in_valid <= i_btn.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_btn.ready) begin
            r_in_action <= i_btn.action;
            r_in_left <= i_btn.btn_left;
            r_in_right <= i_btn.btn_right;
            r_in_hazard <= i_btn.btn_hazard;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_phase = r_phase;
        n_cycles = r_cycles;
        n_ticking = r_ticking;
        n_left_latched = r_left_latched;
        n_right_latched = r_right_latched;
        n_hazard_latched = r_hazard_latched;
        n_held_left = r_held_left;
        n_held_right = r_held_right;
        n_off_sent = r_off_sent;
        n_lamp_left = r_lamp_left;
        n_lamp_right = r_lamp_right;
        emit = 1'b0;
        lit = 1'b0;

        if (r_in_action) begin
            if (r_ticking) begin
                emit = 1'b1;
                n_phase = r_phase + 8'd1;
                lit = (n_phase <= r_on_ticks);
                case (r_mode)
                    MODE_LEFT: begin
                        n_lamp_left = lit;
                        n_lamp_right = 1'b0;
                    end
                    MODE_RIGHT: begin
                        n_lamp_left = 1'b0;
                        n_lamp_right = lit;
                    end
                    MODE_HAZARD: begin
                        n_lamp_left = lit;
                        n_lamp_right = lit;
                    end
                    default: ;
                endcase
                // period boundary
                if (n_phase >= r_period_ticks) begin
                    n_phase = '0;
                    if (r_cycles != CountMax) begin
                        n_cycles = r_cycles + 8'd1;
                    end
                    // direction run ends once released and long enough
                    if ((r_mode == MODE_LEFT || r_mode == MODE_RIGHT) &&
                        n_cycles >= r_min_cycles && !r_held_left && !r_held_right) begin
                        n_lamp_left = 1'b0;
                        n_lamp_right = 1'b0;
                        n_mode = MODE_IDLE;
                        n_ticking = 1'b0;
                        n_left_latched = 1'b0;
                        n_right_latched = 1'b0;
                        n_cycles = '0;
                    end
                end
            end
        end else begin
            n_held_left = r_in_left;
            n_held_right = r_in_right;
            if (r_in_hazard) begin
                n_off_sent = 1'b0;
                n_mode = MODE_HAZARD;
                n_lamp_left = 1'b0;
                n_lamp_right = 1'b0;
                n_left_latched = 1'b0;
                n_right_latched = 1'b0;
                if (!r_hazard_latched) begin
                    n_hazard_latched = 1'b1;
                    n_phase = '0;
                    n_cycles = '0;
                    n_ticking = 1'b1;
                end
            end else begin
                n_hazard_latched = 1'b0;
                if (r_mode == MODE_HAZARD) begin
                    n_mode = MODE_IDLE;
                    n_ticking = 1'b0;
                end
                // right wins over left
                if (r_in_right) begin
                    n_mode = MODE_RIGHT;
                    n_left_latched = 1'b0;
                    n_lamp_left = 1'b0;
                    if (!r_right_latched) begin
                        n_right_latched = 1'b1;
                        n_phase = '0;
                        n_cycles = '0;
                        n_ticking = 1'b1;
                    end
                end else if (r_in_left) begin
                    n_mode = MODE_LEFT;
                    n_right_latched = 1'b0;
                    n_lamp_right = 1'b0;
                    if (!r_left_latched) begin
                        n_left_latched = 1'b1;
                        n_phase = '0;
                        n_cycles = '0;
                        n_ticking = 1'b1;
                    end
                end
                // hazard released: one dark word
                if (!r_off_sent) begin
                    n_off_sent = 1'b1;
                    n_lamp_left = 1'b0;
                    n_lamp_right = 1'b0;
                    emit = 1'b1;
                end
            end
        end

        n_out_valid = process_word && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_phase <= '0;
            r_cycles <= '0;
            r_ticking <= 1'b0;
            r_left_latched <= 1'b0;
            r_right_latched <= 1'b0;
            r_hazard_latched <= 1'b0;
            r_held_left <= 1'b0;
            r_held_right <= 1'b0;
            r_off_sent <= 1'b1;
            r_lamp_left <= 1'b0;
            r_lamp_right <= 1'b0;
        end else if (process_word) begin
            r_mode <= n_mode;
            r_phase <= n_phase;
            r_cycles <= n_cycles;
            r_ticking <= n_ticking;
            r_left_latched <= n_left_latched;
            r_right_latched <= n_right_latched;
            r_hazard_latched <= n_hazard_latched;
            r_held_left <= n_held_left;
            r_held_right <= n_held_right;
            r_off_sent <= n_off_sent;
            r_lamp_left <= n_lamp_left;
            r_lamp_right <= n_lamp_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_left <= n_lamp_left;
            r_out_right <= n_lamp_right;
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the turn signal flasher with a lamp word predictor
module testbench
    import tsf_pkg::*;
();

    localparam logic ActButtons = 1'b0;
    localparam logic ActTick = 1'b1;
    localparam int unsigned RandomWords = 1950;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned HoldCycles = 200;
    localparam int unsigned IdlePct = 16;

    typedef struct packed {
        logic action;
        logic left;
        logic right;
        logic hazard;
    } t_btn_word;

    typedef struct packed {
        logic left;
        logic right;
    } t_lamp_word;

    typedef enum logic [1:0] {
        ROW_CHECKED,
        ROW_NO_WORD,
        ROW_LAMPS,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_btn_word  word;
        t_lamp_word lamps;
        logic [7:0] on_v;
        logic [7:0] per_v;
        logic [7:0] min_v;
    } t_dir_row;

    // word bits: action, left, right, hazard
    localparam t_dir_row DirRows [23] = '{
        '{ROW_NO_WORD, 4'b1000, 2'b00, 8'd0, 8'd0, 8'd0},  // tick while idle
        '{ROW_NO_WORD, 4'b0001, 2'b00, 8'd0, 8'd0, 8'd0},  // hazard press
        '{ROW_LAMPS,   4'b1000, 2'b11, 8'd0, 8'd0, 8'd0},
        '{ROW_LAMPS,   4'b0000, 2'b00, 8'd0, 8'd0, 8'd0},  // hazard release
        '{ROW_NO_WORD, 4'b0000, 2'b00, 8'd0, 8'd0, 8'd0},  // off word already sent
        '{ROW_NO_WORD, 4'b0110, 2'b00, 8'd0, 8'd0, 8'd0},  // both directions, right wins
        '{ROW_LAMPS,   4'b1000, 2'b01, 8'd0, 8'd0, 8'd0},
        '{ROW_NO_WORD, 4'b0100, 2'b00, 8'd0, 8'd0, 8'd0},  // change to left
        '{ROW_LAMPS,   4'b1000, 2'b10, 8'd0, 8'd0, 8'd0},
        '{ROW_NO_WORD, 4'b0111, 2'b00, 8'd0, 8'd0, 8'd0},  // hazard over directions
        '{ROW_LAMPS,   4'b0100, 2'b00, 8'd0, 8'd0, 8'd0},  // release into left
        '{ROW_NO_WORD, 4'b0000, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_CFG,     4'b0000, 2'b00, 8'd1, 8'd2, 8'd1},
        '{ROW_CHECKED, 4'b1000, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_LAMPS,   4'b1000, 2'b00, 8'd0, 8'd0, 8'd0},  // run end tick
        '{ROW_NO_WORD, 4'b1000, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_CFG,     4'b0000, 2'b00, 8'd255, 8'd255, 8'd255},
        '{ROW_NO_WORD, 4'b0010, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_CHECKED, 4'b1000, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_NO_WORD, 4'b0001, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_CHECKED, 4'b1000, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_LAMPS,   4'b0000, 2'b00, 8'd0, 8'd0, 8'd0},
        '{ROW_NO_WORD, 4'b1000, 2'b00, 8'd0, 8'd0, 8'd0}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    t_cfg_idx               cfg_idx;
    logic [CfgWidth-1:0]    cfg_data;

    tsf_in_if  btn_if ();
    tsf_out_if lamp_if ();

    turn_signal_flasher u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_btn      (btn_if),
        .o_lamp     (lamp_if)
    );

    // flasher state as the predictor sees it
    t_mode      fl_mode;
    logic [7:0] fl_phase;
    logic [7:0] fl_cycles;
    logic       fl_ticking;
    logic       fl_lat_left;
    logic       fl_lat_right;
    logic       fl_lat_hazard;
    logic       fl_held_left;
    logic       fl_held_right;
    logic       fl_off_sent;
    logic       fl_lamp_left;
    logic       fl_lamp_right;
    logic [7:0] on_ticks;
    logic [7:0] period_ticks;
    logic [7:0] min_cycles;

    t_lamp_word  lamp_expect_q [$];
    int unsigned words_offered = 0;
    int unsigned words_counted = 0;
    int unsigned lamps_seen = 0;
    int unsigned mismatches = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic start_blink_run();
        fl_phase = '0;
        fl_cycles = '0;
        fl_ticking = 1'b1;
    endtask

    task automatic predict_lamps(input t_btn_word w, output logic has_lamps,
                                 output t_lamp_word lamps);
        logic lit;
        has_lamps = 1'b0;
        if (w.action == ActTick) begin
            if (fl_ticking) begin
                fl_phase = fl_phase + 8'd1;
                lit = fl_phase <= on_ticks;
                case (fl_mode)
                    MODE_LEFT: begin
                        fl_lamp_left = lit;
                        fl_lamp_right = 1'b0;
                    end
                    MODE_RIGHT: begin
                        fl_lamp_left = 1'b0;
                        fl_lamp_right = lit;
                    end
                    MODE_HAZARD: begin
                        fl_lamp_left = lit;
                        fl_lamp_right = lit;
                    end
                    default: ;
                endcase
                if (fl_phase >= period_ticks) begin
                    fl_phase = '0;
                    if (fl_cycles != CountMax) fl_cycles = fl_cycles + 8'd1;
                    // direction run may stop once long enough and released
                    if ((fl_mode == MODE_LEFT || fl_mode == MODE_RIGHT) &&
                        fl_cycles >= min_cycles && !fl_held_left && !fl_held_right) begin
                        fl_lamp_left = 1'b0;
                        fl_lamp_right = 1'b0;
                        fl_mode = MODE_IDLE;
                        fl_ticking = 1'b0;
                        fl_lat_left = 1'b0;
                        fl_lat_right = 1'b0;
                        fl_cycles = '0;
                    end
                end
                has_lamps = 1'b1;
            end
        end else begin
            fl_held_left = w.left;
            fl_held_right = w.right;
            if (w.hazard) begin
                fl_off_sent = 1'b0;
                fl_mode = MODE_HAZARD;
                fl_lamp_left = 1'b0;
                fl_lamp_right = 1'b0;
                fl_lat_left = 1'b0;
                fl_lat_right = 1'b0;
                if (!fl_lat_hazard) begin
                    fl_lat_hazard = 1'b1;
                    start_blink_run();
                end
            end else begin
                fl_lat_hazard = 1'b0;
                if (fl_mode == MODE_HAZARD) begin
                    fl_mode = MODE_IDLE;
                    fl_ticking = 1'b0;
                end
                if (w.right) begin
                    fl_mode = MODE_RIGHT;
                    fl_lat_left = 1'b0;
                    fl_lamp_left = 1'b0;
                    if (!fl_lat_right) begin
                        fl_lat_right = 1'b1;
                        start_blink_run();
                    end
                end else if (w.left) begin
                    fl_mode = MODE_LEFT;
                    fl_lat_right = 1'b0;
                    fl_lamp_right = 1'b0;
                    if (!fl_lat_left) begin
                        fl_lat_left = 1'b1;
                        start_blink_run();
                    end
                end
                // hazard just released: one dark word
                if (!fl_off_sent) begin
                    fl_off_sent = 1'b1;
                    fl_lamp_left = 1'b0;
                    fl_lamp_right = 1'b0;
                    has_lamps = 1'b1;
                end
            end
        end
        lamps.left = fl_lamp_left;
        lamps.right = fl_lamp_right;
    endtask

    task automatic offer_word(input t_btn_word w, input t_row_kind kind,
                              input t_lamp_word typed);
        logic       has_lamps;
        t_lamp_word lamps;
        @(negedge i_clk);
        while (!(words_offered >= 800 && words_offered < 1100) &&
               $urandom_range(99) < IdlePct) begin
            btn_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        btn_if.valid <= 1'b1;
        btn_if.action <= w.action;
        btn_if.btn_left <= w.left;
        btn_if.btn_right <= w.right;
        btn_if.btn_hazard <= w.hazard;
        @(posedge i_clk);
        while (!btn_if.ready) @(posedge i_clk);
        predict_lamps(w, has_lamps, lamps);
        case (kind)
            ROW_LAMPS: lamp_expect_q.push_back(typed);
            ROW_NO_WORD: ;
            default: if (has_lamps) lamp_expect_q.push_back(lamps);
        endcase
        words_offered++;
        words_counted++;
    endtask

    task automatic send_random(input t_btn_word w);
        offer_word(w, ROW_CHECKED, 2'b00);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_random({ActTick, 3'b000});
    endtask

    task automatic write_cfg(input logic [7:0] on_v, input logic [7:0] per_v,
                             input logic [7:0] min_v);
        @(negedge i_clk);
        btn_if.valid <= 1'b0;
        while (lamp_expect_q.size() != 0) @(negedge i_clk);
        // words that give no lamp word may still be in flight
        repeat (DrainCycles) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_ON_TICKS;
        cfg_data <= on_v;
        @(negedge i_clk);
        cfg_idx <= CFG_PERIOD_TICKS;
        cfg_data <= per_v;
        @(negedge i_clk);
        cfg_idx <= CFG_MIN_CYCLES;
        cfg_data <= min_v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        on_ticks = on_v;
        period_ticks = per_v;
        min_cycles = min_v;
    endtask

    task automatic drive_scenario();
        int unsigned pick;
        int unsigned span;
        t_btn_word   w;
        span = period_ticks * (min_cycles + 1) + 2;
        if (span > 60) span = 60;
        pick = $urandom_range(99);
        if (pick < 45) begin
            // direction press, blink, maybe the other side, release, then more ticks
            w = {ActButtons, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0};
            if (!w.left && !w.right) w.left = 1'b1;
            send_random(w);
            send_ticks($urandom_range(span / 2));
            if ($urandom_range(99) < 30) begin
                send_random({ActButtons, !w.left, !w.right, 1'b0});
                send_ticks($urandom_range(span / 2));
            end
            send_random({ActButtons, 3'b000});
            send_ticks($urandom_range(span));
        end else if (pick < 70) begin
            send_random({ActButtons, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1});
            send_ticks($urandom_range(span));
            if ($urandom_range(99) < 30) begin
                send_random({ActButtons, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1});
                send_ticks($urandom_range(span / 2));
            end
            send_random({ActButtons, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0});
            send_ticks($urandom_range(span));
        end else begin
            repeat ($urandom_range(1, 6)) send_random(4'($urandom_range(15)));
        end
    endtask

    // lamp word sink: random stalls, one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            lamp_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && lamps_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            lamp_if.ready <= 1'b0;
        end else begin
            lamp_if.ready <= (lamps_seen >= 600 && lamps_seen < 900) ||
                             ($urandom_range(99) >= IdlePct);
        end
    end

    always @(posedge i_clk) begin
        t_lamp_word want;
        if (i_rst_n && lamp_if.valid && lamp_if.ready) begin
            if (lamp_expect_q.size() == 0) begin
                $error("unexpected lamp word: left_lamp %0b right_lamp %0b",
                       lamp_if.left_lamp, lamp_if.right_lamp);
                mismatches++;
            end else begin
                want = lamp_expect_q.pop_front();
                if (lamp_if.left_lamp !== want.left) begin
                    $error("left_lamp: expected %0b, got %0b", want.left, lamp_if.left_lamp);
                    mismatches++;
                end
                if (lamp_if.right_lamp !== want.right) begin
                    $error("right_lamp: expected %0b, got %0b", want.right, lamp_if.right_lamp);
                    mismatches++;
                end
            end
            lamps_seen++;
        end
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [7:0] per;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ON_TICKS;
        cfg_data = '0;
        btn_if.valid = 1'b0;
        btn_if.action = ActButtons;
        btn_if.btn_left = 1'b0;
        btn_if.btn_right = 1'b0;
        btn_if.btn_hazard = 1'b0;
        lamp_if.ready = 1'b0;
        on_ticks = OnTicksReset;
        period_ticks = PeriodTicksReset;
        min_cycles = MinCyclesReset;
        fl_mode = MODE_IDLE;
        fl_phase = '0;
        fl_cycles = '0;
        fl_ticking = 1'b0;
        fl_lat_left = 1'b0;
        fl_lat_right = 1'b0;
        fl_lat_hazard = 1'b0;
        fl_held_left = 1'b0;
        fl_held_right = 1'b0;
        fl_off_sent = 1'b1;
        fl_lamp_left = 1'b0;
        fl_lamp_right = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DirRows[i]) begin
            if (DirRows[i].kind == ROW_CFG)
                write_cfg(DirRows[i].on_v, DirRows[i].per_v, DirRows[i].min_v);
            else
                offer_word(DirRows[i].word, DirRows[i].kind, DirRows[i].lamps);
        end

        words_counted = 0;
        while (words_counted < RandomWords) begin
            case ($urandom_range(9))
                0: write_cfg(CountMax, CountMax, CountMax);
                1: write_cfg(8'd1, 8'd2, 8'd1);
                2: write_cfg(8'($urandom_range(1, 255)), 8'($urandom_range(2, 255)),
                             8'($urandom_range(1, 255)));
                default: begin
                    per = 8'($urandom_range(2, 12));
                    write_cfg(8'($urandom_range(1, per + 1)), per, 8'($urandom_range(1, 4)));
                end
            endcase
            repeat (15) begin
                if (words_counted < RandomWords) drive_scenario();
            end
        end

        @(negedge i_clk);
        btn_if.valid <= 1'b0;
        while (lamp_expect_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/tsf_pkg.sv
hw/rtl/tsf_in_if.sv
hw/rtl/tsf_out_if.sv
hw/rtl/turn_signal_flasher.sv
tb/testbench.sv
